/* src/mrd_pkg.sv */
package mrd_pkg;

  // Frame delimiters and direction marks
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_M      = 8'h4D;  // 'M'
  localparam logic [7:0] CH_REQ    = 8'h3C;  // '<'
  localparam logic [7:0] CH_RSP    = 8'h3E;  // '>'

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef enum logic [3:0] {
    ST_START,
    ST_M,
    ST_DIR,
    ST_LEN,
    ST_CMD,
    ST_DATA,
    ST_SUM,
    ST_RD,
    ST_LD
  } mrd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic ld_dir;
    logic ld_len;
    logic ld_cmd;
    logic wr_data;
    logic cnt_good;
    logic cnt_bad;
    logic rd_start;
    logic rd_issue;
    logic out_single;
    logic out_read;
  } mrd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_dollar;
    logic is_m;
    logic is_dir;
    logic len_ok;
    logic len_zero;
    logic fill_done;
    logic sum_ok;
    logic is_req;
    logic rd_last;
    logic out_free;
  } mrd_sts_t;

endpackage

/* src/mrd_ram.sv */
module mrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/mrd_ctrl.sv */
module mrd_ctrl import mrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mrd_sts_t   sts_i,
  output mrd_cmd_t   cmd_o,
  output mrd_state_e state_o
);

  mrd_state_e state_q, state_d;
  logic       acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    acc        = 1'b0;
    case (state_q)
      ST_START, ST_M, ST_DIR, ST_LEN, ST_CMD, ST_DATA: in_ready_o = 1'b1;
      // the checksum byte may produce a result at once, so hold it until the slot is free
      ST_SUM:  in_ready_o = sts_i.out_free;
      default: in_ready_o = 1'b0;
    endcase
    acc = in_valid_i && in_ready_o;

    case (state_q)
      ST_START: begin
        if (acc && sts_i.is_dollar) state_d = ST_M;
      end
      ST_M: begin
        if (acc) state_d = sts_i.is_m ? ST_DIR : ST_START;
      end
      ST_DIR: begin
        if (acc) begin
          if (sts_i.is_dir) begin
            cmd_o.ld_dir = 1'b1;
            state_d      = ST_LEN;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_LEN: begin
        if (acc) begin
          if (sts_i.len_ok) begin
            cmd_o.ld_len = 1'b1;
            state_d      = ST_CMD;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_CMD: begin
        if (acc) begin
          cmd_o.ld_cmd = 1'b1;
          state_d      = sts_i.len_zero ? ST_SUM : ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd_o.wr_data = 1'b1;
          if (sts_i.fill_done) state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (acc) begin
          state_d = ST_START;
          if (sts_i.is_req) begin
            if (sts_i.sum_ok) begin
              cmd_o.cnt_good = 1'b1;
              if (sts_i.len_zero) begin
                cmd_o.out_single = 1'b1;
              end else begin
                cmd_o.rd_start = 1'b1;
                state_d        = ST_RD;
              end
            end else begin
              cmd_o.cnt_bad    = 1'b1;
              cmd_o.out_single = 1'b1;
            end
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LD;
      end
      ST_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_read = 1'b1;
          state_d        = sts_i.rd_last ? ST_START : ST_RD;
        end
      end
      default: state_d = ST_START;
    endcase
  end

  assign state_o = state_q;

endmodule

/* src/mrd_datapath.sv */
module mrd_datapath import mrd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             rx_byte_i,
  input  mrd_cmd_t               cmd_i,
  output mrd_sts_t               sts_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_status_o,
  output logic                   out_last_o
);

  logic             is_req_q, is_req_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       xor_q, xor_d;
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] good_q, good_d;
  logic [CNT_W-1:0] bad_q, bad_d;
  logic [LEN_W-1:0] fill_inc;
  logic [LEN_W-1:0] rd_next;
  logic [7:0]       ram_rdata;
  logic             out_ld;

  // result register
  logic             ov_q, ov_d;
  logic             os_q, os_d;
  logic             ol_q, ol_d;
  logic [IDX_W-1:0] oi_q, oi_d;
  logic [7:0]       ob_q, ob_d;
  logic [7:0]       oc_q, oc_d;
  logic [LEN_W-1:0] on_q, on_d;
  logic [CNT_W-1:0] og_q, og_d;
  logic [CNT_W-1:0] oe_q, oe_d;

  mrd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_data),
    .waddr_i(fill_q[IDX_W-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  assign fill_inc = fill_q + LEN_W'(1);
  assign rd_next  = LEN_W'(rd_idx_q) + LEN_W'(1);
  assign out_ld   = cmd_i.out_single || cmd_i.out_read;

  always_comb begin
    sts_o.is_dollar = (rx_byte_i == CH_DOLLAR);
    sts_o.is_m      = (rx_byte_i == CH_M);
    sts_o.is_dir    = rx_byte_i inside {CH_REQ, CH_RSP};
    sts_o.len_ok    = (rx_byte_i <= MAX_PAYLOAD_B);
    sts_o.len_zero  = (len_q == '0);
    sts_o.fill_done = (fill_inc >= len_q);
    sts_o.sum_ok    = (rx_byte_i == xor_q);
    sts_o.is_req    = is_req_q;
    sts_o.rd_last   = (rd_next == len_q);
    sts_o.out_free  = !ov_q || out_ready_i;
  end

  always_comb begin
    is_req_d = is_req_q;
    len_d    = len_q;
    cmd_d    = cmd_q;
    xor_d    = xor_q;
    fill_d   = fill_q;
    rd_idx_d = rd_idx_q;
    good_d   = good_q;
    bad_d    = bad_q;
    if (cmd_i.ld_dir) is_req_d = (rx_byte_i == CH_REQ);
    if (cmd_i.ld_len) begin
      len_d  = rx_byte_i[LEN_W-1:0];
      xor_d  = rx_byte_i;
      fill_d = '0;
    end
    if (cmd_i.ld_cmd) begin
      cmd_d = rx_byte_i;
      xor_d = xor_q ^ rx_byte_i;
    end
    if (cmd_i.wr_data) begin
      xor_d  = xor_q ^ rx_byte_i;
      fill_d = fill_inc;
    end
    if (cmd_i.cnt_good) good_d = good_q + CNT_W'(1);
    if (cmd_i.cnt_bad)  bad_d  = bad_q + CNT_W'(1);
    if (cmd_i.rd_start) rd_idx_d = '0;
    if (cmd_i.out_read) rd_idx_d = rd_idx_q + IDX_W'(1);
  end

  always_comb begin
    ov_d = ov_q && !out_ready_i;
    os_d = os_q;
    ol_d = ol_q;
    oi_d = oi_q;
    ob_d = ob_q;
    oc_d = oc_q;
    on_d = on_q;
    og_d = og_q;
    oe_d = oe_q;
    if (out_ld) begin
      ov_d = 1'b1;
      oc_d = cmd_q;
      on_d = len_q;
      og_d = good_d;
      oe_d = bad_d;
    end
    if (cmd_i.out_single) begin
      os_d = cmd_i.cnt_bad ? STATUS_BAD : STATUS_GOOD;
      ol_d = 1'b1;
      oi_d = '0;
      ob_d = '0;
    end
    if (cmd_i.out_read) begin
      os_d = STATUS_GOOD;
      ol_d = sts_o.rd_last;
      oi_d = rd_idx_q;
      ob_d = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      good_q <= '0;
      bad_q  <= '0;
    end else begin
      ov_q   <= ov_d;
      good_q <= good_d;
      bad_q  <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_req_q <= is_req_d;
    len_q    <= len_d;
    cmd_q    <= cmd_d;
    xor_q    <= xor_d;
    fill_q   <= fill_d;
    rd_idx_q <= rd_idx_d;
    os_q     <= os_d;
    ol_q     <= ol_d;
    oi_q     <= oi_d;
    ob_q     <= ob_d;
    oc_q     <= oc_d;
    on_q     <= on_d;
    og_q     <= og_d;
    oe_q     <= oe_d;
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = os_q;
  assign out_last_o   = ol_q;
  assign out_data_o   = {3'b000, oe_q, og_q, ob_q, oi_q, on_q, oc_q};

endmodule

/* src/msp_v1_request_deframer.sv */
// Request deframer for MSP v1 serial frames. Feed received bytes one per request
// on the slave stream; the block tracks '$' 'M' direction length command payload
// checksum, XORing length, command and payload, and stores payload bytes in a
// 64-entry RAM. A wrong 'M', an unknown direction byte or a length above 64 drops
// the frame and the parser waits for '$' again. Response frames ('>') end
// without output. A good request frame ('<') gives one result per payload byte,
// or one result with data 0 for an empty payload; a checksum failure gives one
// error result (tuser high). tlast marks the final result of each frame. Each
// header and payload byte is taken whatever the master side does; the checksum
// byte is held until the result register is free. After a good request frame
// the input stalls while the store is read back, each result by a RAM read and
// then a result load. The good and bad frame counters wrap at 16 bits and are
// reported with every result.
module msp_v1_request_deframer import mrd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,  // [7:0] rx_byte
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [7:0] command_code, [14:8] frame_length, [20:15] byte_index,
  // [28:21] data_byte, [44:29] good_frames, [60:45] bad_frames, [63:61] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tuser_o,  // [0] status: 1 checksum error
  output logic                   m_axis_tlast_o
);

  mrd_cmd_t   cmd;
  mrd_sts_t   sts;
  mrd_state_e state;

  // Controller: frame phase and readout sequencing
  mrd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .state_o   (state)
  );

  // Datapath: header latches, checksum, payload store, counters, result register
  mrd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_status_o(m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // An error result is always the single, final result of its frame
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o[28:15] == '0))
    else $error("error result without tlast or with nonzero index/data");

  // Never load a result over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_single || cmd.out_read) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten");

  // Counters move only on an accepted checksum byte
  a_count_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cnt_good || cmd.cnt_bad) |-> (s_axis_tvalid_i && s_axis_tready_o && state == ST_SUM))
    else $error("frame counter changed outside checksum byte");

  // No byte is taken as payload readout starts
  a_readout_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_start |=> (state == ST_RD && !s_axis_tready_o))
    else $error("readout did not start or input not stalled");

endmodule

/* bench/mrd_result_checker.sv */
module mrd_result_checker import mrd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [7:0]             s_axis_tdata_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                   m_axis_tuser_i,
  input  logic                   m_axis_tlast_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  typedef enum logic [2:0] {
    WAIT_DOLLAR,
    WAIT_M,
    WAIT_DIR,
    WAIT_LEN,
    WAIT_CMD,
    WAIT_PAYLOAD,
    WAIT_SUM
  } parse_phase_e;

  typedef struct packed {
    logic             status;
    logic [7:0]       command_code;
    logic [LEN_W-1:0] frame_length;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       data_byte;
    logic             last;
    logic [CNT_W-1:0] good_frames;
    logic [CNT_W-1:0] bad_frames;
  } frame_result_t;

  parse_phase_e     phase = WAIT_DOLLAR;
  logic             in_request = 1'b0;
  logic [LEN_W-1:0] frame_len = '0;
  logic [7:0]       frame_cmd = '0;
  logic [7:0]       sum_acc = '0;
  logic [LEN_W-1:0] fill_ptr = '0;
  logic [7:0]       payload_mem [STORE_DEPTH];
  logic [CNT_W-1:0] good_total = '0;
  logic [CNT_W-1:0] bad_total = '0;

  frame_result_t frame_results_q [$];
  int unsigned   mismatches = 0;

  task automatic drop_frame();
    phase      = WAIT_DOLLAR;
    in_request = 1'b0;
    frame_len  = '0;
    frame_cmd  = '0;
    sum_acc    = '0;
    fill_ptr   = '0;
  endtask

  function automatic frame_result_t make_result(input logic st, input logic [IDX_W-1:0] idx,
                                                input logic [7:0] data, input logic lst);
    frame_result_t r;
    r.status       = st;
    r.command_code = frame_cmd;
    r.frame_length = frame_len;
    r.byte_index   = idx;
    r.data_byte    = data;
    r.last         = lst;
    r.good_frames  = good_total;
    r.bad_frames   = bad_total;
    return r;
  endfunction

  // Advance the parser by one received byte; queue what the frame end produces.
  task automatic advance_parser(input logic [7:0] rx);
    int unsigned i;
    case (phase)
      WAIT_DOLLAR: begin
        if (rx == CH_DOLLAR) phase = WAIT_M;
      end
      WAIT_M: begin
        // a second '$' is not taken as a new start
        phase = (rx == CH_M) ? WAIT_DIR : WAIT_DOLLAR;
      end
      WAIT_DIR: begin
        if (rx == CH_REQ || rx == CH_RSP) begin
          in_request = (rx == CH_REQ);
          phase      = WAIT_LEN;
        end else begin
          drop_frame();
        end
      end
      WAIT_LEN: begin
        if (rx > MAX_PAYLOAD_B) begin
          drop_frame();
        end else begin
          frame_len = rx[LEN_W-1:0];
          sum_acc   = rx;
          fill_ptr  = '0;
          phase     = WAIT_CMD;
        end
      end
      WAIT_CMD: begin
        frame_cmd = rx;
        sum_acc   = sum_acc ^ rx;
        phase     = (frame_len != 0) ? WAIT_PAYLOAD : WAIT_SUM;
      end
      WAIT_PAYLOAD: begin
        payload_mem[fill_ptr[IDX_W-1:0]] = rx;
        sum_acc  = sum_acc ^ rx;
        fill_ptr = fill_ptr + 1'b1;
        if (fill_ptr >= frame_len) phase = WAIT_SUM;
      end
      WAIT_SUM: begin
        if (in_request) begin
          if (rx == sum_acc) begin
            good_total = good_total + 1'b1;
            if (frame_len == 0) begin
              frame_results_q.push_back(make_result(STATUS_GOOD, '0, '0, 1'b1));
            end else begin
              for (i = 0; i < frame_len; i++) begin
                frame_results_q.push_back(make_result(STATUS_GOOD, IDX_W'(i),
                                                      payload_mem[IDX_W'(i)],
                                                      (i + 1 == frame_len)));
              end
            end
          end else begin
            bad_total = bad_total + 1'b1;
            frame_results_q.push_back(make_result(STATUS_BAD, '0, '0, 1'b1));
          end
        end
        drop_frame();
      end
      default: drop_frame();
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      // check the output first: a result cannot stem from a byte taken at the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result, got tdata %h tuser %b tlast %b", $time,
                   m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
          mismatches++;
        end else begin
          want = frame_results_q.pop_front();
          compare_field("status", want.status, m_axis_tuser_i);
          compare_field("command_code", want.command_code, m_axis_tdata_i[7:0]);
          compare_field("frame_length", want.frame_length, m_axis_tdata_i[14:8]);
          compare_field("byte_index", want.byte_index, m_axis_tdata_i[20:15]);
          compare_field("data_byte", want.data_byte, m_axis_tdata_i[28:21]);
          compare_field("last", want.last, m_axis_tlast_i);
          compare_field("good_frames", want.good_frames, m_axis_tdata_i[44:29]);
          compare_field("bad_frames", want.bad_frames, m_axis_tdata_i[60:45]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) advance_parser(s_axis_tdata_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= frame_results_q.size();
  end

endmodule

/* bench/tb.sv */
module tb;
  import mrd_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_BYTES  = 430;

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_valid = 1'b0;
  logic [7:0]             s_data = '0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic                   m_user;
  logic                   m_last;
  int unsigned            fail_count;
  int unsigned            pending;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        long_hold = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned bytes_sent = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  msp_v1_request_deframer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  mrd_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .m_axis_tlast_i  (m_last),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Result side: random back-pressure, plus one long hold once the stimulus asks for it.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (long_hold && hold_cycles < HOLD_CYCLES) begin
      m_ready     <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one byte, idling first at random; return once it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Send a whole frame with random payload; corrupt the checksum on request.
  task automatic send_frame(input logic [7:0] dir, input int unsigned len,
                            input logic [7:0] cmd, input bit bad_sum);
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned i;
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(dir);
    send_byte(8'(len));
    sum = 8'(len) ^ cmd;
    send_byte(cmd);
    for (i = 0; i < len; i++) begin
      b   = 8'($urandom);
      sum = sum ^ b;
      send_byte(b);
    end
    send_byte(bad_sum ? (sum ^ 8'($urandom_range(255, 1))) : sum);
  endtask

  // Mostly short payloads, now and then up to the full 64.
  function automatic int unsigned pick_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(6);
    if (p < 95) return $urandom_range(40, 7);
    return $urandom_range(MAX_PAYLOAD, 41);
  endfunction

  task automatic send_random_traffic();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_frame(CH_REQ, pick_length(), 8'($urandom), $urandom_range(9) == 0);
    end else if (pick < 72) begin
      send_frame(CH_RSP, pick_length(), 8'($urandom), $urandom_range(1) == 1);
    end else if (pick < 80) begin
      // truncated header: whatever follows is parsed as the rest of this frame
      send_byte(CH_DOLLAR);
      send_byte(CH_M);
      send_byte($urandom_range(1) ? CH_REQ : CH_RSP);
      if ($urandom_range(1)) send_byte(8'($urandom_range(8)));
    end else if (pick < 86) begin
      send_byte(CH_DOLLAR);
      send_byte(CH_M);
      send_byte($urandom_range(1) ? CH_REQ : CH_RSP);
      send_byte(8'($urandom_range(255, MAX_PAYLOAD + 1)));
    end else if (pick < 91) begin
      send_byte(CH_DOLLAR);
      send_byte(CH_M);
      send_byte(8'($urandom));
    end else if (pick < 95) begin
      send_byte(CH_DOLLAR);
      send_byte(8'($urandom));
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) send_byte(8'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    tx_idle_pct <= 9;
    rx_idle_pct <= 60;
    @(posedge clk_i);

    // Directed: empty request with extreme command codes
    send_frame(CH_REQ, 0, 8'h00, 1'b0);
    send_frame(CH_REQ, 0, 8'hFF, 1'b0);
    // payload with all-zero and all-one bytes: len 2, cmd FF, data 00 FF
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(CH_REQ);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h02);
    // checksum error on a request, then a response that ends silently
    send_frame(CH_REQ, 1, 8'h5A, 1'b1);
    send_frame(CH_RSP, 0, 8'h11, 1'b0);
    // wrong 'M', a repeated '$', bad direction, length just past the limit
    send_byte(CH_DOLLAR);
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(8'h21);
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(CH_REQ);
    send_byte(8'(MAX_PAYLOAD + 1));

    // Random: sender light / receiver heavy idling, then swapped, then none
    while (bytes_sent < RAND_BYTES / 3) send_random_traffic();
    tx_idle_pct <= 60;
    rx_idle_pct <= 9;
    while (bytes_sent < 2 * RAND_BYTES / 3) send_random_traffic();
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    // Hold the result side off while a full-size frame and more follow
    long_hold <= 1'b1;
    send_frame(CH_REQ, MAX_PAYLOAD, 8'($urandom), 1'b0);
    send_frame(CH_REQ, 3, 8'($urandom), 1'b0);
    send_frame(CH_REQ, MAX_PAYLOAD - 1, 8'($urandom), 1'b0);
    while (bytes_sent < RAND_BYTES) send_random_traffic();

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * MAX_PAYLOAD + 20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
